// ----- rtl/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Types, constants and codes shared by the point to ellipse distance block.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int          ITER_MAX  = 100;
    localparam logic [7:0]  ITER_LAST = 8'(ITER_MAX);

    localparam logic [63:0] EPS_Q30   = 64'd10737;
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] CAP_Q     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] CAP_SQ    = 64'h2000_0000_0000_0000;
    localparam logic [63:0] COORD_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] DIST_MAX  = 64'h0000_0000_FFFF_FFFF;
    localparam logic signed [65:0] T_MAX = 66'sh0_4000_0000_0000_0000;

    localparam logic [1:0]  STAT_OK     = 2'd0;
    localparam logic [1:0]  STAT_LIMIT  = 2'd1;
    localparam logic [1:0]  STAT_CENTER = 2'd2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        axis_x;
        logic [30:0]        axis_y;
    } t_in;

    typedef struct packed {
        logic [31:0]        distance;
        logic signed [31:0] nearest_x;
        logic signed [31:0] nearest_y;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [1:0] {
        CLS_CIRCLE,
        CLS_GENERAL,
        CLS_MAJOR,
        CLS_MINOR
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] u;
        logic [31:0] v;
        logic [30:0] a;
        logic [30:0] b;
        logic        flipx;
        logic        flipy;
        logic        swapped;
    } t_job;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] lo;
    } t_areq;

    typedef struct packed {
        logic         done;
        logic         ovf;
        logic [127:0] res;
    } t_arsp;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_WAIT,
        S_H0, S_H1, S_H2, S_H3,
        S_C1, S_C2, S_C3, S_C4,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
        S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8, S_G9,
        S_G10, S_G11, S_G12, S_G13, S_GEND, S_G14, S_G15,
        S_DONE
    } t_bstate;

endpackage

// ----- rtl/point_ellipse_distance_top.sv -----
// ----------------------------------------------------------------------------
// point_ellipse_distance_top
// Distance from a point to an origin-centered axis-aligned ellipse, with
// the nearest ellipse point, in Q16.16.
// ----------------------------------------------------------------------------
// channel   ports                        transfer
// input     start, busy, i_item          start && !busy at the clock edge
// result    o_done, o_result             o_done high for one cycle
//
// one transaction is solved at a time on a shared unit that multiplies,
// divides and takes square roots, the last two one bit a cycle.
// the general case runs at most 100 newton steps.
// a two-entry queue lets two more transactions wait; busy is high while full.
// reset is synchronous, active low; results cannot be held off.
// ----------------------------------------------------------------------------
module point_ellipse_distance_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ped_pkg::t_in  i_item,
    output logic          o_done,
    output ped_pkg::t_out o_result
);

    logic           w_push, w_pop, w_full, w_empty;
    ped_pkg::t_job  w_fjob, w_qjob;
    ped_pkg::t_areq w_req;
    ped_pkg::t_arsp w_rsp;

    ped_front u_front (
        .start  (start),
        .i_item (i_item),
        .i_full (w_full),
        .busy   (busy),
        .o_push (w_push),
        .o_job  (w_fjob)
    );

    ped_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ped_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    ped_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_job    (w_qjob),
        .o_pop    (w_pop),
        .o_req    (w_req),
        .i_rsp    (w_rsp),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ----- rtl/ped_arith.sv -----
// ----------------------------------------------------------------------------
// ped_arith
// Shared multi-cycle unit: 64x64 multiply from 32x32 partial products,
// 128/64 restoring divide and 128-bit square root, one bit per cycle.
// ----------------------------------------------------------------------------
module ped_arith (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ped_pkg::t_areq i_req,
    output ped_pkg::t_arsp o_rsp
);

    logic           r_busy, n_busy;
    ped_pkg::t_op   r_op, n_op;
    logic [5:0]     r_cnt, n_cnt;
    logic [63:0]    r_x, n_x;
    logic [63:0]    r_y, n_y;
    logic [63:0]    r_lo, n_lo;
    logic [127:0]   r_acc, n_acc;
    logic [65:0]    r_rem, n_rem;
    logic [63:0]    r_root, n_root;
    logic           r_done, n_done;
    logic           r_ovf, n_ovf;

    logic [31:0]    w_xs, w_ys;
    logic [63:0]    w_pp;
    logic [1:0]     w_k;
    logic [64:0]    w_dt, w_dd;
    logic           w_dge;
    logic [67:0]    w_rs, w_trial;
    logic           w_sge;

    assign w_xs    = r_cnt[1] ? r_x[63:32] : r_x[31:0];
    assign w_ys    = r_cnt[0] ? r_y[63:32] : r_y[31:0];
    assign w_pp    = w_xs * w_ys;
    assign w_k     = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    assign w_dt    = {r_rem[63:0], r_lo[63]};
    assign w_dd    = {1'b0, r_y};
    assign w_dge   = w_dt >= w_dd;
    assign w_rs    = {r_rem, r_x[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = w_rs >= w_trial;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_lo   = r_lo;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_root = r_root;
        n_done = 1'b0;
        n_ovf  = r_ovf;
        if (!r_busy) begin
            if (i_req.start) begin
                n_op   = i_req.op;
                n_x    = i_req.x;
                n_y    = i_req.y;
                n_lo   = i_req.lo;
                n_cnt  = '0;
                n_acc  = '0;
                n_rem  = {2'b00, i_req.x};
                n_root = '0;
                n_ovf  = 1'b0;
                if (i_req.op == ped_pkg::OP_SQRT) begin
                    n_rem = '0;
                end
                if (i_req.op == ped_pkg::OP_DIV && (i_req.y == '0 || i_req.x >= i_req.y)) begin
                    n_ovf  = 1'b1;
                    n_done = 1'b1;
                end else begin
                    n_busy = 1'b1;
                end
            end
        end else begin
            n_cnt = r_cnt + 6'd1;
            case (r_op)
                ped_pkg::OP_MUL: begin
                    n_acc = r_acc + ({64'b0, w_pp} << {w_k, 5'b0});
                    if (r_cnt == 6'd3) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                ped_pkg::OP_DIV: begin
                    n_rem = {2'b00, (w_dge ? 64'(w_dt - w_dd) : w_dt[63:0])};
                    n_lo  = {r_lo[62:0], w_dge};
                    if (r_cnt == 6'd63) begin
                        n_acc  = {64'b0, r_lo[62:0], w_dge};
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                ped_pkg::OP_SQRT: begin
                    n_rem  = w_sge ? 66'(w_rs - w_trial) : w_rs[65:0];
                    n_root = {r_root[62:0], w_sge};
                    n_x    = {r_x[61:0], r_lo[63:62]};
                    n_lo   = {r_lo[61:0], 2'b00};
                    if (r_cnt == 6'd63) begin
                        n_acc  = {64'b0, r_root[62:0], w_sge};
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ped_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_lo   <= n_lo;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_ovf  <= n_ovf;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.res  = r_acc;

endmodule

// ----- rtl/ped_front.sv -----
// ----------------------------------------------------------------------------
// ped_front
// Accepts a transaction, folds the point into the first quadrant, orders
// the axes and classifies the job for the back end.
// ----------------------------------------------------------------------------
module ped_front (
    input  logic          start,
    input  ped_pkg::t_in  i_item,
    input  logic          i_full,
    output logic          busy,
    output logic          o_push,
    output ped_pkg::t_job o_job
);

    logic [31:0] w_mx, w_my;
    logic        w_circle, w_swap;
    logic [31:0] w_u, w_v;

    assign w_mx     = i_item.point_x[31] ? 32'(-i_item.point_x) : i_item.point_x;
    assign w_my     = i_item.point_y[31] ? 32'(-i_item.point_y) : i_item.point_y;
    assign w_circle = i_item.axis_x == i_item.axis_y;
    assign w_swap   = !w_circle && (i_item.axis_x < i_item.axis_y);
    assign w_u      = w_swap ? w_my : w_mx;
    assign w_v      = w_swap ? w_mx : w_my;

    always_comb begin
        o_job.u       = w_u;
        o_job.v       = w_v;
        o_job.a       = w_swap ? i_item.axis_y : i_item.axis_x;
        o_job.b       = w_swap ? i_item.axis_x : i_item.axis_y;
        o_job.flipx   = i_item.point_x[31];
        o_job.flipy   = i_item.point_y[31];
        o_job.swapped = w_swap;
        if (w_circle) begin
            o_job.cls = ped_pkg::CLS_CIRCLE;
        end else if (w_u == '0) begin
            o_job.cls = ped_pkg::CLS_MINOR;
        end else if (w_v == '0) begin
            o_job.cls = ped_pkg::CLS_MAJOR;
        end else begin
            o_job.cls = ped_pkg::CLS_GENERAL;
        end
    end

    assign busy   = i_full;
    assign o_push = start && !i_full;

endmodule

// ----- rtl/ped_queue.sv -----
// ----------------------------------------------------------------------------
// ped_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module ped_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ped_pkg::t_job i_job,
    input  logic          i_pop,
    output ped_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    ped_pkg::t_job r_mem [2];
    logic          r_wptr, n_wptr;
    logic          r_rptr, n_rptr;
    logic [1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rptr];
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_cnt == 2'd3))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push && r_cnt == 2'd1) |=> o_empty)
        else $error("queue not empty after last pop");
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && r_cnt == 2'd1) |=> o_full)
        else $error("queue not full after second push");
`endif

endmodule

// ----- rtl/ped_back.sv -----
// ----------------------------------------------------------------------------
// ped_back
// Sequencer that solves one job at a time on the shared arithmetic unit:
// circle, axis cases and the Newton iteration, then unfolds the result.
// ----------------------------------------------------------------------------
module ped_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ped_pkg::t_job  i_job,
    output logic           o_pop,
    output ped_pkg::t_areq o_req,
    input  ped_pkg::t_arsp i_rsp,
    output logic           o_done,
    output ped_pkg::t_out  o_result
);

    ped_pkg::t_bstate r_state, n_state;
    ped_pkg::t_bstate r_ret, n_ret;
    ped_pkg::t_job    r_job, n_job;
    logic [63:0]      r_aa, n_aa;
    logic [63:0]      r_bb, n_bb;
    logic [63:0]      r_au, n_au;
    logic [63:0]      r_bv, n_bv;
    logic signed [63:0] r_t, n_t;
    logic [63:0]      r_p, n_p;
    logic [63:0]      r_q, n_q;
    logic [63:0]      r_x, n_x;
    logic [63:0]      r_y, n_y;
    logic [63:0]      r_x2, n_x2;
    logic [63:0]      r_y2, n_y2;
    logic [63:0]      r_f, n_f;
    logic [63:0]      r_w, n_w;
    logic [63:0]      r_len, n_len;
    logic [63:0]      r_sq, n_sq;
    logic [63:0]      r_dist, n_dist;
    logic [31:0]      r_ox, n_ox;
    logic [31:0]      r_oy, n_oy;
    logic [31:0]      r_hx, n_hx;
    logic [31:0]      r_hy, n_hy;
    logic [1:0]       r_status, n_status;
    logic [7:0]       r_iter, n_iter;
    logic             r_conv, n_conv;
    logic             r_done, n_done;
    ped_pkg::t_out    r_out, n_out;

    logic [63:0]      a64, b64, u64, v64;
    logic [63:0]      w_res;
    logic [63:0]      w_capq, w_sq, w_coord, w_xs;
    logic signed [65:0] w_t66, w_pp, w_qq, w_t0, w_lim, w_tsum;
    logic [63:0]      w_p, w_q, w_w, w_tnext;
    logic signed [63:0] w_f;
    logic [31:0]      w_nx, w_ny;

    function automatic logic [63:0] f_sat(input logic [127:0] p, input logic [63:0] cap);
        logic [63:0] v;
        v = p[93:30];
        if (|p[127:94] || v > cap) begin
            f_sat = cap;
        end else begin
            f_sat = v;
        end
    endfunction

    function automatic logic [31:0] f_absdiff(input logic [31:0] p, input logic [31:0] q);
        f_absdiff = (p > q) ? (p - q) : (q - p);
    endfunction

    assign a64     = {33'b0, r_job.a};
    assign b64     = {33'b0, r_job.b};
    assign u64     = {32'b0, r_job.u};
    assign v64     = {32'b0, r_job.v};
    assign w_res   = i_rsp.res[63:0];
    assign w_capq  = (i_rsp.ovf || w_res > ped_pkg::CAP_Q) ? ped_pkg::CAP_Q : w_res;
    assign w_xs    = (i_rsp.ovf || w_res > ped_pkg::COORD_MAX) ? ped_pkg::COORD_MAX : w_res;
    assign w_sq    = f_sat(i_rsp.res, ped_pkg::CAP_SQ);
    assign w_coord = f_sat(i_rsp.res, ped_pkg::COORD_MAX);
    assign w_t66   = {{2{r_t[63]}}, r_t};
    assign w_pp    = w_t66 + $signed({2'b00, r_aa});
    assign w_qq    = w_t66 + $signed({2'b00, r_bb});
    assign w_p     = (w_pp < 66'sd1) ? 64'd1 : w_pp[63:0];
    assign w_q     = (w_qq < 66'sd1) ? 64'd1 : w_qq[63:0];
    assign w_t0    = $signed({4'b0, w_res[63:2]}) - $signed({2'b00, r_bb});
    assign w_f     = $signed(r_x2 + w_sq - ped_pkg::ONE_Q30);
    assign w_w     = w_sq + r_y2;
    assign w_lim   = ped_pkg::T_MAX - w_t66;
    assign w_tsum  = w_t66 + $signed({2'b00, w_capq});
    assign w_tnext = ($signed({2'b00, w_capq}) > w_lim) ? ped_pkg::T_MAX[63:0] : w_tsum[63:0];
    assign w_nx    = r_job.swapped ? r_oy : r_ox;
    assign w_ny    = r_job.swapped ? r_ox : r_oy;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_job    = r_job;
        n_aa     = r_aa;
        n_bb     = r_bb;
        n_au     = r_au;
        n_bv     = r_bv;
        n_t      = r_t;
        n_p      = r_p;
        n_q      = r_q;
        n_x      = r_x;
        n_y      = r_y;
        n_x2     = r_x2;
        n_y2     = r_y2;
        n_f      = r_f;
        n_w      = r_w;
        n_len    = r_len;
        n_sq     = r_sq;
        n_dist   = r_dist;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_hx     = r_hx;
        n_hy     = r_hy;
        n_status = r_status;
        n_iter   = r_iter;
        n_conv   = r_conv;
        n_done   = 1'b0;
        n_out    = r_out;
        o_pop    = 1'b0;
        o_req    = '0;
        o_req.op = ped_pkg::OP_MUL;
        case (r_state)
            ped_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_state = ped_pkg::S_DISPATCH;
                end
            end
            ped_pkg::S_DISPATCH: begin
                n_status = ped_pkg::STAT_OK;
                case (r_job.cls)
                    ped_pkg::CLS_MINOR: begin
                        n_ox    = '0;
                        n_oy    = {1'b0, r_job.b};
                        n_dist  = {32'b0, f_absdiff(r_job.v, {1'b0, r_job.b})};
                        n_state = ped_pkg::S_DONE;
                    end
                    ped_pkg::CLS_CIRCLE: begin
                        n_hx    = r_job.u;
                        n_hy    = r_job.v;
                        n_state = ped_pkg::S_H0;
                    end
                    default: begin
                        o_req.start = 1'b1;
                        o_req.x     = a64;
                        o_req.y     = a64;
                        n_ret       = (r_job.cls == ped_pkg::CLS_MAJOR) ? ped_pkg::S_M1
                                                                        : ped_pkg::S_G1;
                        n_state     = ped_pkg::S_WAIT;
                    end
                endcase
            end
            ped_pkg::S_WAIT: begin
                if (i_rsp.done) begin
                    n_state = r_ret;
                end
            end
            // distance from the squared offsets
            ped_pkg::S_H0: begin
                o_req.start = 1'b1;
                o_req.x     = {32'b0, r_hx};
                o_req.y     = {32'b0, r_hx};
                n_ret       = ped_pkg::S_H1;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_H1: begin
                n_sq        = w_res;
                o_req.start = 1'b1;
                o_req.x     = {32'b0, r_hy};
                o_req.y     = {32'b0, r_hy};
                n_ret       = ped_pkg::S_H2;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_H2: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_SQRT;
                o_req.lo    = r_sq + w_res;
                n_ret       = ped_pkg::S_H3;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_H3: begin
                if (r_job.cls == ped_pkg::CLS_CIRCLE) begin
                    n_len = w_res;
                    if (w_res == '0) begin
                        n_dist      = a64;
                        n_ox        = {1'b0, r_job.a};
                        n_oy        = '0;
                        n_status    = ped_pkg::STAT_CENTER;
                        n_job.flipx = 1'b0;
                        n_job.flipy = 1'b0;
                        n_state     = ped_pkg::S_DONE;
                    end else begin
                        o_req.start = 1'b1;
                        o_req.x     = a64;
                        o_req.y     = u64;
                        n_ret       = ped_pkg::S_C1;
                        n_state     = ped_pkg::S_WAIT;
                    end
                end else begin
                    n_dist  = w_res;
                    n_state = ped_pkg::S_DONE;
                end
            end
            // circle
            ped_pkg::S_C1: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.lo    = w_res;
                o_req.y     = r_len;
                n_ret       = ped_pkg::S_C2;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_C2: begin
                n_ox        = w_res[31:0];
                o_req.start = 1'b1;
                o_req.x     = a64;
                o_req.y     = v64;
                n_ret       = ped_pkg::S_C3;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_C3: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.lo    = w_res;
                o_req.y     = r_len;
                n_ret       = ped_pkg::S_C4;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_C4: begin
                n_oy    = w_res[31:0];
                n_dist  = (r_len > a64) ? (r_len - a64) : (a64 - r_len);
                n_state = ped_pkg::S_DONE;
            end
            // point on the major axis
            ped_pkg::S_M1: begin
                n_aa        = w_res;
                o_req.start = 1'b1;
                o_req.x     = b64;
                o_req.y     = b64;
                n_ret       = ped_pkg::S_M2;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M2: begin
                n_bb        = w_res;
                o_req.start = 1'b1;
                o_req.x     = u64;
                o_req.y     = a64;
                n_ret       = ped_pkg::S_M3;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M3: begin
                if (w_res < r_aa - r_bb) begin
                    o_req.start = 1'b1;
                    o_req.x     = r_aa;
                    o_req.y     = u64;
                    n_ret       = ped_pkg::S_M4;
                    n_state     = ped_pkg::S_WAIT;
                end else begin
                    n_ox    = {1'b0, r_job.a};
                    n_oy    = '0;
                    n_dist  = {32'b0, f_absdiff(r_job.u, {1'b0, r_job.a})};
                    n_state = ped_pkg::S_DONE;
                end
            end
            ped_pkg::S_M4: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.x     = i_rsp.res[127:64];
                o_req.lo    = w_res;
                o_req.y     = r_aa - r_bb;
                n_ret       = ped_pkg::S_M5;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M5: begin
                n_ox        = w_xs[31:0];
                o_req.start = 1'b1;
                o_req.x     = w_xs;
                o_req.y     = w_xs;
                n_ret       = ped_pkg::S_M6;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M6: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_SQRT;
                o_req.lo    = r_aa - w_res;
                n_ret       = ped_pkg::S_M7;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M7: begin
                o_req.start = 1'b1;
                o_req.x     = b64;
                o_req.y     = w_res;
                n_ret       = ped_pkg::S_M8;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M8: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.lo    = w_res;
                o_req.y     = a64;
                n_ret       = ped_pkg::S_M9;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_M9: begin
                n_oy    = w_res[31:0];
                n_hx    = f_absdiff(r_ox, r_job.u);
                n_hy    = w_res[31:0];
                n_state = ped_pkg::S_H0;
            end
            // general case setup
            ped_pkg::S_G1: begin
                n_aa        = {2'b00, w_res[63:2]};
                o_req.start = 1'b1;
                o_req.x     = b64;
                o_req.y     = b64;
                n_ret       = ped_pkg::S_G2;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G2: begin
                n_bb        = {2'b00, w_res[63:2]};
                o_req.start = 1'b1;
                o_req.x     = a64;
                o_req.y     = u64;
                n_ret       = ped_pkg::S_G3;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G3: begin
                n_au        = w_res;
                o_req.start = 1'b1;
                o_req.x     = b64;
                o_req.y     = v64;
                n_ret       = ped_pkg::S_G4;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G4: begin
                n_bv    = w_res;
                n_t     = w_t0[63:0];
                n_iter  = '0;
                n_x     = '0;
                n_y     = '0;
                n_conv  = 1'b0;
                n_state = ped_pkg::S_G5;
            end
            // newton step
            ped_pkg::S_G5: begin
                n_p         = w_p;
                n_q         = w_q;
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.x     = r_au >> 36;
                o_req.lo    = r_au << 28;
                o_req.y     = w_p;
                n_ret       = ped_pkg::S_G6;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G6: begin
                n_x         = w_capq;
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.x     = r_bv >> 36;
                o_req.lo    = r_bv << 28;
                o_req.y     = r_q;
                n_ret       = ped_pkg::S_G7;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G7: begin
                n_y         = w_capq;
                o_req.start = 1'b1;
                o_req.x     = r_x;
                o_req.y     = r_x;
                n_ret       = ped_pkg::S_G8;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G8: begin
                n_x2        = w_sq;
                o_req.start = 1'b1;
                o_req.x     = r_y;
                o_req.y     = r_y;
                n_ret       = ped_pkg::S_G9;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G9: begin
                n_y2 = w_sq;
                n_f  = w_f;
                if (w_f < $signed(ped_pkg::EPS_Q30)) begin
                    n_conv  = 1'b1;
                    n_state = ped_pkg::S_GEND;
                end else begin
                    o_req.start = 1'b1;
                    o_req.op    = ped_pkg::OP_DIV;
                    o_req.x     = r_q >> 34;
                    o_req.lo    = r_q << 30;
                    o_req.y     = r_p;
                    n_ret       = ped_pkg::S_G10;
                    n_state     = ped_pkg::S_WAIT;
                end
            end
            ped_pkg::S_G10: begin
                o_req.start = 1'b1;
                o_req.x     = r_x2;
                o_req.y     = w_capq;
                n_ret       = ped_pkg::S_G11;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G11: begin
                n_w = w_w;
                if (w_w == '0) begin
                    n_conv  = 1'b1;
                    n_state = ped_pkg::S_GEND;
                end else begin
                    o_req.start = 1'b1;
                    o_req.x     = r_f;
                    o_req.y     = r_q;
                    n_ret       = ped_pkg::S_G12;
                    n_state     = ped_pkg::S_WAIT;
                end
            end
            ped_pkg::S_G12: begin
                o_req.start = 1'b1;
                o_req.op    = ped_pkg::OP_DIV;
                o_req.x     = i_rsp.res[127:64];
                o_req.lo    = w_res;
                o_req.y     = {r_w[62:0], 1'b0};
                n_ret       = ped_pkg::S_G13;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G13: begin
                if (w_capq < ped_pkg::EPS_Q30) begin
                    n_conv  = 1'b1;
                    n_state = ped_pkg::S_GEND;
                end else begin
                    n_t    = w_tnext;
                    n_iter = r_iter + 8'd1;
                    if (r_iter + 8'd1 == ped_pkg::ITER_LAST) begin
                        n_state = ped_pkg::S_GEND;
                    end else begin
                        n_state = ped_pkg::S_G5;
                    end
                end
            end
            ped_pkg::S_GEND: begin
                n_status    = r_conv ? ped_pkg::STAT_OK : ped_pkg::STAT_LIMIT;
                o_req.start = 1'b1;
                o_req.x     = r_x;
                o_req.y     = a64;
                n_ret       = ped_pkg::S_G14;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G14: begin
                n_ox        = w_coord[31:0];
                o_req.start = 1'b1;
                o_req.x     = r_y;
                o_req.y     = b64;
                n_ret       = ped_pkg::S_G15;
                n_state     = ped_pkg::S_WAIT;
            end
            ped_pkg::S_G15: begin
                n_oy    = w_coord[31:0];
                n_hx    = f_absdiff(r_ox, r_job.u);
                n_hy    = f_absdiff(w_coord[31:0], r_job.v);
                n_state = ped_pkg::S_H0;
            end
            // unfold and report
            ped_pkg::S_DONE: begin
                n_out.distance  = (r_dist > ped_pkg::DIST_MAX) ? ped_pkg::DIST_MAX[31:0]
                                                               : r_dist[31:0];
                n_out.nearest_x = r_job.flipx ? -w_nx : w_nx;
                n_out.nearest_y = r_job.flipy ? -w_ny : w_ny;
                n_out.status    = r_status;
                n_done          = 1'b1;
                n_state         = ped_pkg::S_IDLE;
            end
            default: begin
                n_state = ped_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ped_pkg::S_IDLE;
            r_ret   <= ped_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_done  <= n_done;
        end
        r_job    <= n_job;
        r_aa     <= n_aa;
        r_bb     <= n_bb;
        r_au     <= n_au;
        r_bv     <= n_bv;
        r_t      <= n_t;
        r_p      <= n_p;
        r_q      <= n_q;
        r_x      <= n_x;
        r_y      <= n_y;
        r_x2     <= n_x2;
        r_y2     <= n_y2;
        r_f      <= n_f;
        r_w      <= n_w;
        r_len    <= n_len;
        r_sq     <= n_sq;
        r_dist   <= n_dist;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_hx     <= n_hx;
        r_hy     <= n_hy;
        r_status <= n_status;
        r_iter   <= n_iter;
        r_conv   <= n_conv;
        r_out    <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ped_pkg::S_DONE) |=> r_done)
        else $error("result strobe missing after completion");
    a_rsp_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.done |-> (r_state == ped_pkg::S_WAIT))
        else $error("arithmetic result while not waiting");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe longer than one cycle");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ped_pkg::S_G5) |-> (r_iter < ped_pkg::ITER_LAST))
        else $error("newton step beyond iteration limit");
`endif

endmodule
